FILE: rtl/core/arsa_pkg.sv
// shared types and constants for the address range size align block
`default_nettype none

package arsa_pkg;

   localparam int ADDR_W = 32;
   localparam int CNT_W  = $clog2(ADDR_W);

   typedef logic [ADDR_W-1:0] addr_type;

   typedef struct packed {
      addr_type block_start;
      addr_type block_end;
      addr_type next_start;
      logic     has_next;
   } req_type;

   typedef struct packed {
      addr_type fill_start;
      addr_type fill_end;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // take the input item
      logic run_open;   // a run is in progress at load time
      logic div_step;   // one remainder bit
      logic pad_calc;   // pad from remainder
      logic end_calc;   // padded end with saturation
      logic dec;        // clip to the next range
      logic out_load;   // write the result register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic keep_open;
      logic emit;
   } sts_type;

endpackage

`default_nettype wire

FILE: rtl/core/arsa_dp.sv
// datapath: run start, serial remainder unit, pad and clipping logic, result register
`default_nettype none

module arsa_dp (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  cfg_we,
   input  wire arsa_pkg::addr_type cfg_data,
   input  wire arsa_pkg::req_type  req_data,
   input  wire arsa_pkg::cmd_type  cmd,
   output arsa_pkg::sts_type       sts,
   output arsa_pkg::rsp_type       rsp_data
);
   import arsa_pkg::*;

   addr_type align_ff;
   addr_type run_start_ff, run_start_in;
   addr_type be_ff, limit_ff;
   logic     more_ff;
   addr_type a_ff, am1_ff, a_in, am1_in;
   addr_type div_ff, rem_ff, rem_in;
   addr_type pad_ff, end_ff, fill_end_ff;
   logic     pad_zero_ff;
   rsp_type  rsp_ff;

   logic [ADDR_W:0] shifted, trial;
   logic            ge;
   logic            sat, no_pad, clip;
   addr_type        final_end;

   // granule zero behaves as one
   always_comb begin
      a_in         = (align_ff == '0) ? addr_type'(1) : align_ff;
      am1_in       = a_in - addr_type'(1);
      run_start_in = cmd.run_open ? run_start_ff : req_data.block_start;
   end

   // restoring remainder step
   always_comb begin
      shifted = {rem_ff, div_ff[ADDR_W-1]};
      trial   = shifted - {1'b0, a_ff};
      ge      = shifted >= {1'b0, a_ff};
      rem_in  = ge ? trial[ADDR_W-1:0] : shifted[ADDR_W-1:0];
   end

   always_comb begin
      sat       = pad_ff > ~be_ff;
      no_pad    = pad_zero_ff || (end_ff == be_ff);
      clip      = more_ff && !(end_ff < limit_ff);
      final_end = clip ? limit_ff : end_ff;
      sts.keep_open = !no_pad && clip;
      sts.emit      = !no_pad && (be_ff != '1) && (final_end > be_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         align_ff     <= addr_type'(1);
         run_start_ff <= '0;
      end else begin
         if (cfg_we) begin
            align_ff <= cfg_data;
         end
         if (cmd.load) begin
            run_start_ff <= run_start_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         be_ff    <= req_data.block_end;
         limit_ff <= req_data.next_start - addr_type'(1);
         more_ff  <= req_data.has_next;
         a_ff     <= a_in;
         am1_ff   <= am1_in;
         div_ff   <= req_data.block_end - run_start_in;
         rem_ff   <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= rem_in;
         div_ff <= {div_ff[ADDR_W-2:0], 1'b0};
      end
      if (cmd.pad_calc) begin
         // (a - 1) - (span mod a) equals the pad, zero when already aligned
         pad_ff <= am1_ff - rem_ff;
      end
      if (cmd.end_calc) begin
         end_ff      <= sat ? '1 : be_ff + pad_ff;
         pad_zero_ff <= pad_ff == '0;
      end
      if (cmd.dec) begin
         fill_end_ff <= final_end;
      end
      if (cmd.out_load) begin
         rsp_ff.fill_start <= be_ff + addr_type'(1);
         rsp_ff.fill_end   <= fill_end_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

FILE: rtl/core/arsa_ctrl.sv
// controller: sequences load, remainder steps, pad, clip and result write
`default_nettype none

module arsa_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   input  wire arsa_pkg::sts_type sts,
   output arsa_pkg::cmd_type      cmd
);
   import arsa_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_PAD,
      ST_END,
      ST_DEC,
      ST_WR
   } state_type;

   state_type        state_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             run_open_ff;
   logic             rsp_valid_ff;
   logic             out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.run_open = run_open_ff;
      unique case (state_ff)
         ST_IDLE: cmd.load     = req_valid;
         ST_DIV:  cmd.div_step = 1'b1;
         ST_PAD:  cmd.pad_calc = 1'b1;
         ST_END:  cmd.end_calc = 1'b1;
         ST_DEC:  cmd.dec      = 1'b1;
         ST_WR:   cmd.out_load = out_free;
         default: cmd          = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         run_open_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // result register empties on a transfer unless refilled below
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  cnt_ff      <= '0;
                  run_open_ff <= 1'b1;
                  state_ff    <= ST_DIV;
               end
            end
            ST_DIV: begin
               cnt_ff <= cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(ADDR_W - 1)) begin
                  state_ff <= ST_PAD;
               end
            end
            ST_PAD: state_ff <= ST_END;
            ST_END: state_ff <= ST_DEC;
            ST_DEC: begin
               run_open_ff <= sts.keep_open;
               state_ff    <= sts.emit ? ST_WR : ST_IDLE;
            end
            ST_WR: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_load_to_div: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == ST_DIV) && (cnt_ff == '0) && run_open_ff)
      else $error("accepted item did not start the remainder steps");

   a_div_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) && (cnt_ff == CNT_W'(ADDR_W - 1)) |=> state_ff == ST_PAD)
      else $error("remainder unit did not finish after the last bit");

   a_out_only_wr: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (state_ff == ST_WR) && out_free)
      else $error("result register written outside the write step");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_WR))
      else $error("result appeared without a write step");

endmodule

`default_nettype wire

FILE: rtl/core/address_range_size_align.sv
// top level of the address range size align block
//
//  channel | valid     | flow control | payload
//  --------+-----------+--------------+---------------------------------------
//  req     | req_valid | req_stall    | req_data: block_start, block_end,
//          |           |              |           next_start, has_next
//  rsp     | rsp_valid | rsp_stall    | rsp_data: fill_start, fill_end
//  csr     | csr_valid | csr_ready    | csr_data: align_size
//
//  between one transfer and the next possible transfer a range passes through these steps:
//  the accept cycle, 32 remainder steps (one address bit per cycle through a shared
//  restoring unit), pad, saturated end, clip and, only for a fill, the result write
//  synchronous active high reset closes any run, sets align_size to 1
//  results sit in an output register; a new range is taken while one waits
//  a stalled result holds the write step until the register frees up
`default_nettype none

module address_range_size_align (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   input  wire arsa_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output arsa_pkg::rsp_type       rsp_data,
   input  wire                     csr_valid,
   output logic                    csr_ready,
   input  wire arsa_pkg::addr_type csr_data
);
   import arsa_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   arsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   arsa_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cfg_we   (csr_valid && csr_ready),
      .cfg_data (csr_data),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire
